FILE: design/systick_timer_with_cycle_count_assert.svh
// Assertion macros shared by the timer modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SYSTICK_TIMER_WITH_CYCLE_COUNT_ASSERT_SVH
`define SYSTICK_TIMER_WITH_CYCLE_COUNT_ASSERT_SVH

// Same-cycle implication
`define STC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/stc_pkg.sv
package stc_pkg;

  // Default sizes of the counter and the wrap count
  localparam int COUNTER_BITS_DEF = 24;
  localparam int WRAP_BITS_DEF    = 32;

  // Item field widths
  localparam int OP_BITS   = 2;
  localparam int SEL_BITS  = 3;
  localparam int DATA_BITS = 32;
  localparam int READ_BITS = 56;
  localparam int CTL_BITS  = 3;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_WRITE = 2'd2;

  // Register selects
  localparam logic [SEL_BITS-1:0] REG_CTRL    = 3'd0;
  localparam logic [SEL_BITS-1:0] REG_RELOAD  = 3'd1;
  localparam logic [SEL_BITS-1:0] REG_CURRENT = 3'd2;
  localparam logic [SEL_BITS-1:0] REG_CALIB   = 3'd3;
  localparam logic [SEL_BITS-1:0] REG_STATUS  = 3'd4;
  localparam logic [SEL_BITS-1:0] REG_CYCLE   = 3'd5;

  // Bit positions in control and status
  localparam int CTL_ENABLE_BIT  = 0;
  localparam int CTL_TICKINT_BIT = 1;
  localparam int CTL_CLKSRC_BIT  = 2;
  localparam int CTL_FLAG_POS    = 16;
  localparam int STAT_CLR_BIT    = 25;
  localparam int STAT_SET_BIT    = 26;

  // One item as held in the input register
  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [SEL_BITS-1:0]  sel;
    logic [DATA_BITS-1:0] data;
    logic                 core;
  } item_t;

endpackage

FILE: design/stc_core.sv
`include "systick_timer_with_cycle_count_assert.svh"

module stc_core import stc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int WRAP_BITS    = WRAP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  item_t                item,
  output logic [READ_BITS-1:0] rd_data,
  output logic                 pending
);

  logic [COUNTER_BITS-1:0] cur_r, cur_nxt;
  logic [COUNTER_BITS-1:0] rel_r, rel_nxt;
  logic [CTL_BITS-1:0]     ctl_r, ctl_nxt;
  logic                    flag_r, flag_nxt;
  logic                    pend_r, pend_nxt;
  logic [WRAP_BITS-1:0]    wrap_r, wrap_nxt;
  logic [COUNTER_BITS+WRAP_BITS+READ_BITS-1:0] cyc_full;

  // Wrap count above the elapsed ticks of this period (mask - current)
  assign cyc_full = {{READ_BITS{1'b0}}, wrap_r, ~cur_r};

  // Work out the next state and the read value for one item
  always_comb begin
    cur_nxt  = cur_r;
    rel_nxt  = rel_r;
    ctl_nxt  = ctl_r;
    flag_nxt = flag_r;
    pend_nxt = pend_r;
    wrap_nxt = wrap_r;
    rd_data  = '0;
    case (item.op)
      OP_TICK: begin
        if (ctl_r[CTL_ENABLE_BIT] && (item.core == ctl_r[CTL_CLKSRC_BIT])) begin
          if (cur_r != '0) begin
            cur_nxt = cur_r - COUNTER_BITS'(1);
          end else if (rel_r != '0) begin
            // wrap: reload, flag, pend if the tick interrupt is enabled, count
            cur_nxt  = rel_r;
            flag_nxt = 1'b1;
            if (ctl_r[CTL_TICKINT_BIT]) begin
              pend_nxt = 1'b1;
            end
            wrap_nxt = wrap_r + WRAP_BITS'(1);
          end
        end
      end
      OP_READ: begin
        case (item.sel)
          REG_CTRL: begin
            rd_data[CTL_BITS-1:0]  = ctl_r;
            rd_data[CTL_FLAG_POS]  = flag_r;
            flag_nxt               = 1'b0;
          end
          REG_RELOAD:  rd_data = {{(READ_BITS-COUNTER_BITS){1'b0}}, rel_r};
          REG_CURRENT: rd_data = {{(READ_BITS-COUNTER_BITS){1'b0}}, cur_r};
          REG_STATUS:  rd_data[STAT_SET_BIT] = pend_r;
          REG_CYCLE:   rd_data = cyc_full[READ_BITS-1:0];
          default:     rd_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (item.sel)
          REG_CTRL:    ctl_nxt = item.data[CTL_BITS-1:0];
          REG_RELOAD:  rel_nxt = item.data[COUNTER_BITS-1:0];
          REG_CURRENT: begin
            cur_nxt  = '0;
            flag_nxt = 1'b0;
          end
          // clear wins over set
          REG_STATUS:  pend_nxt = (pend_r | item.data[STAT_SET_BIT])
                                  & ~item.data[STAT_CLR_BIT];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign pending = pend_nxt;

  // Commit the state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      rel_r  <= '0;
      ctl_r  <= '0;
      flag_r <= 1'b0;
      pend_r <= 1'b0;
      wrap_r <= '0;
    end else if (fire) begin
      cur_r  <= cur_nxt;
      rel_r  <= rel_nxt;
      ctl_r  <= ctl_nxt;
      flag_r <= flag_nxt;
      pend_r <= pend_nxt;
      wrap_r <= wrap_nxt;
    end
  end

  `STC_ASSERT_NXT(a_cur_write_clears, fire && (item.op == OP_WRITE) && (item.sel == REG_CURRENT), (cur_r == '0) && !flag_r, "current write did not clear counter and flag")
  `STC_ASSERT_NXT(a_wrap_hold, !fire, $stable(wrap_r) && $stable(cur_r), "state moved without an item")
  `STC_ASSERT_IMP(a_wrap_reload, fire && (wrap_nxt != wrap_r), (cur_nxt == rel_r) && (cur_r == '0), "wrap count moved without a reload")

endmodule

FILE: design/systick_timer_with_cycle_count.sv
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless a result waits on out_stall; one timer pass per item.
// While a result waits on out_stall, the input register still takes one item, then stalls.
// Reset (rst_n low, synchronous) clears counter, reload, control, flag,
// pending bit and wrap count, and empties both registers.
`include "systick_timer_with_cycle_count_assert.svh"

module systick_timer_with_cycle_count import stc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int WRAP_BITS    = WRAP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_BITS-1:0]   in_operation,
  input  logic [SEL_BITS-1:0]  in_reg_select,
  input  logic [DATA_BITS-1:0] in_write_data,
  input  logic                 in_tick_is_core,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [READ_BITS-1:0] out_read_data,
  output logic                 out_irq_pending
);

  logic                 s1_valid_r;
  item_t                s1_item_r;
  logic                 out_valid_r;
  logic [READ_BITS-1:0] rd_r;
  logic                 irq_r;
  logic                 adv;
  logic                 fire;
  logic [READ_BITS-1:0] rd_calc;
  logic                 pend_calc;

  // Result register can take a new item
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r.op   <= in_operation;
      s1_item_r.sel  <= in_reg_select;
      s1_item_r.data <= in_write_data;
      s1_item_r.core <= in_tick_is_core;
    end
  end

  stc_core #(
    .COUNTER_BITS(COUNTER_BITS),
    .WRAP_BITS   (WRAP_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .rd_data(rd_calc),
    .pending(pend_calc)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r  <= rd_calc;
      irq_r <= pend_calc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = rd_r;
  assign out_irq_pending = irq_r;

  `STC_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_r, "input stalled while empty")
  `STC_ASSERT_NXT(a_item_moves_on, s1_valid_r && !out_stall, out_valid_r, "held item not passed on")
  `STC_ASSERT_NXT(a_drain, out_valid_r && !out_stall && !s1_valid_r, !out_valid_r, "result repeated")

endmodule

FILE: sim/tb.sv
module tb import stc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = COUNTER_BITS_DEF;
  localparam int WRAP_W = WRAP_BITS_DEF;
  localparam int TARGET_ITEMS = 1500;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 150;
  localparam int MAX_PRINTS = 20;

  // Codes that the package leaves unnamed
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [SEL_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [SEL_BITS-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [READ_BITS-1:0] read_data;
    logic                 irq_pending;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] in_operation = '0;
  logic [SEL_BITS-1:0] in_reg_select = '0;
  logic [DATA_BITS-1:0] in_write_data = '0;
  logic in_tick_is_core = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [READ_BITS-1:0] out_read_data;
  logic out_irq_pending;

  // Timer state as the checker sees it
  logic [CNT_W-1:0] tmr_current;
  logic [CNT_W-1:0] tmr_reload;
  logic [CTL_BITS-1:0] tmr_ctl;
  logic tmr_flag;
  logic tmr_pending;
  logic [WRAP_W-1:0] tmr_wraps;

  item_t pending_items[$];
  timer_result_t awaited_results[$];

  int mismatch_count = 0;
  int tick_count = 0;
  int read_count = 0;
  int write_count = 0;
  int other_count = 0;
  int reload_events = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int out_count = 0;
  int idle_cycles = 0;
  int phase_cycles = 0;
  logic calm = 1'b0;

  systick_timer_with_cycle_count dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_reg_select   (in_reg_select),
    .in_write_data   (in_write_data),
    .in_tick_is_core (in_tick_is_core),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_irq_pending (out_irq_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic add_item(input logic [OP_BITS-1:0] op, input logic [SEL_BITS-1:0] sel,
                          input logic [DATA_BITS-1:0] data, input logic core);
    item_t it;
    it.op = op;
    it.sel = sel;
    it.data = data;
    it.core = core;
    pending_items.push_back(it);
  endtask

  // Mostly short gaps, now and then a long one, none in a calm phase
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one accepted item to the timer state and queue its result
  task automatic advance_timer(input item_t it);
    logic [READ_BITS-1:0] rd;
    timer_result_t res;
    rd = '0;
    case (it.op)
      OP_TICK: begin
        tick_count++;
        if (tmr_ctl[CTL_ENABLE_BIT] && it.core == tmr_ctl[CTL_CLKSRC_BIT]) begin
          if (tmr_current != '0) begin
            tmr_current = tmr_current - CNT_W'(1);
          end else if (tmr_reload != '0) begin
            tmr_current = tmr_reload;
            tmr_flag = 1'b1;
            if (tmr_ctl[CTL_TICKINT_BIT]) tmr_pending = 1'b1;
            tmr_wraps = tmr_wraps + WRAP_W'(1);
            reload_events++;
          end
        end
      end
      OP_READ: begin
        read_count++;
        case (it.sel)
          REG_CTRL: begin
            rd = READ_BITS'(tmr_ctl) | (READ_BITS'(tmr_flag) << CTL_FLAG_POS);
            tmr_flag = 1'b0;
          end
          REG_RELOAD: rd = READ_BITS'(tmr_reload);
          REG_CURRENT: rd = READ_BITS'(tmr_current);
          REG_STATUS: rd = tmr_pending ? (READ_BITS'(1) << STAT_SET_BIT) : '0;
          REG_CYCLE: rd = {tmr_wraps, {CNT_W{1'b1}} - tmr_current};
          default: rd = '0;
        endcase
      end
      OP_WRITE: begin
        write_count++;
        case (it.sel)
          REG_CTRL: tmr_ctl = it.data[CTL_BITS-1:0];
          REG_RELOAD: tmr_reload = it.data[CNT_W-1:0];
          REG_CURRENT: begin
            tmr_current = '0;
            tmr_flag = 1'b0;
          end
          REG_STATUS: begin
            if (it.data[STAT_SET_BIT]) tmr_pending = 1'b1;
            if (it.data[STAT_CLR_BIT]) tmr_pending = 1'b0;
          end
          default: ;
        endcase
      end
      default: other_count++;
    endcase
    res.read_data = rd;
    res.irq_pending = tmr_pending;
    awaited_results.push_back(res);
  endtask

  task automatic build_stimulus();
    logic [CTL_BITS-1:0] ctl;
    logic [CNT_W-1:0] rl;
    logic core;
    logic [OP_BITS-1:0] op;
    int n_ticks;
    // Reset values of every select, unused ones included
    add_item(OP_READ, REG_CTRL, '0, 1'b0);
    add_item(OP_READ, REG_RELOAD, '0, 1'b0);
    add_item(OP_READ, REG_CURRENT, '0, 1'b0);
    add_item(OP_READ, REG_CALIB, '0, 1'b0);
    add_item(OP_READ, REG_STATUS, '0, 1'b0);
    add_item(OP_READ, REG_CYCLE, '0, 1'b0);
    add_item(OP_READ, REG_UNUSED_LO, '0, 1'b0);
    add_item(OP_READ, REG_UNUSED_HI, '0, 1'b0);
    // Full-width reload truncates, control keeps only its low bits
    add_item(OP_WRITE, REG_RELOAD, '1, 1'b1);
    add_item(OP_READ, REG_RELOAD, '1, 1'b1);
    add_item(OP_WRITE, REG_CTRL, '1, 1'b0);
    // Reload from zero, then a tick of the wrong clock kind
    add_item(OP_TICK, REG_CTRL, '0, 1'b1);
    add_item(OP_TICK, REG_CTRL, '1, 1'b0);
    add_item(OP_READ, REG_CYCLE, '0, 1'b0);
    add_item(OP_READ, REG_CTRL, '0, 1'b0);
    add_item(OP_READ, REG_CTRL, '0, 1'b0);
    // Current write clears whatever the data
    add_item(OP_WRITE, REG_CURRENT, 32'h1234_5678, 1'b0);
    add_item(OP_READ, REG_CURRENT, '0, 1'b0);
    // Set and clear together: clear wins; then set alone
    add_item(OP_WRITE, REG_STATUS, (32'd1 << STAT_SET_BIT) | (32'd1 << STAT_CLR_BIT), 1'b0);
    add_item(OP_WRITE, REG_STATUS, 32'd1 << STAT_SET_BIT, 1'b0);
    add_item(OP_READ, REG_STATUS, '0, 1'b0);
    // Writes that go nowhere, and the unused operation
    add_item(OP_WRITE, REG_CALIB, '1, 1'b0);
    add_item(OP_WRITE, REG_CYCLE, '1, 1'b0);
    add_item(OP_WRITE, REG_UNUSED_HI, '1, 1'b0);
    add_item(OP_UNUSED, REG_CYCLE, '1, 1'b1);
    // Zero reload with counter at zero, then a disabled tick
    add_item(OP_WRITE, REG_RELOAD, '0, 1'b0);
    add_item(OP_WRITE, REG_CTRL, 32'd1 << CTL_ENABLE_BIT, 1'b0);
    add_item(OP_TICK, REG_CTRL, '0, 1'b0);
    add_item(OP_WRITE, REG_CTRL, '0, 1'b0);
    add_item(OP_TICK, REG_CTRL, '0, 1'b0);
    add_item(OP_READ, REG_CYCLE, '0, 1'b0);

    // Mostly programmed count-down runs with random content, the rest noise
    while (pending_items.size() < TARGET_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        ctl = CTL_BITS'($urandom_range(0, 7));
        if ($urandom_range(0, 9) != 0) ctl[CTL_ENABLE_BIT] = 1'b1;
        case ($urandom_range(0, 9))
          0: rl = CNT_W'($urandom());
          1: rl = '0;
          default: rl = CNT_W'($urandom_range(1, 12));
        endcase
        add_item(OP_WRITE, REG_RELOAD, {8'($urandom()), rl}, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) == 1) begin
          add_item(OP_WRITE, REG_CURRENT, $urandom(), 1'($urandom_range(0, 1)));
        end
        add_item(OP_WRITE, REG_CTRL, ($urandom() & ~32'h7) | 32'(ctl),
                 1'($urandom_range(0, 1)));
        n_ticks = $urandom_range(4, 40);
        repeat (n_ticks) begin
          core = ctl[CTL_CLKSRC_BIT];
          if ($urandom_range(0, 9) == 0) core = ~core;
          add_item(OP_TICK, SEL_BITS'($urandom_range(0, 7)), $urandom(), core);
          case ($urandom_range(0, 9))
            0, 1: add_item(OP_READ, SEL_BITS'($urandom_range(0, 7)), $urandom(),
                           1'($urandom_range(0, 1)));
            2: add_item(OP_WRITE, REG_STATUS,
                        ($urandom() & ~(32'h3 << STAT_CLR_BIT)) |
                        (32'($urandom_range(0, 3)) << STAT_CLR_BIT),
                        1'($urandom_range(0, 1)));
            default: ;
          endcase
        end
        add_item(OP_READ, REG_CYCLE, $urandom(), 1'($urandom_range(0, 1)));
        add_item(OP_READ, REG_CTRL, $urandom(), 1'($urandom_range(0, 1)));
      end else begin
        op = ($urandom_range(0, 49) == 0) ? OP_UNUSED : OP_BITS'($urandom_range(0, 2));
        add_item(op, SEL_BITS'($urandom_range(0, 7)), $urandom(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Switch between calm stretches and gappy stretches now and then
  always @(posedge clk) begin
    if (phase_cycles >= 200) begin
      phase_cycles <= 0;
      calm <= ($urandom_range(0, 9) < 3);
    end else begin
      phase_cycles <= phase_cycles + 1;
    end
  end

  // Driver: predict on accept, then offer the next item after its gap
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        it.op = in_operation;
        it.sel = in_reg_select;
        it.data = in_write_data;
        it.core = in_tick_is_core;
        advance_timer(it);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_operation <= it.op;
          in_reg_select <= it.sel;
          in_write_data <= it.data;
          in_tick_is_core <= it.core;
          in_valid <= 1'b1;
          gap_left = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((holds_done == 0 && out_count >= 300) ||
                 (holds_done == 1 && out_count >= 900)) begin
      holds_done++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = draw_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_count++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result read_data=%h irq=%b",
                                  out_read_data, out_irq_pending));
      end else begin
        want = awaited_results.pop_front();
        if (out_read_data !== want.read_data) begin
          report_mismatch($sformatf("result %0d read_data %h, expected %h",
                                    out_count, out_read_data, want.read_data));
        end
        if (out_irq_pending !== want.irq_pending) begin
          report_mismatch($sformatf("result %0d irq_pending %b, expected %b",
                                    out_count, out_irq_pending, want.irq_pending));
        end
      end
    end
  end

  // Watchdog: give up when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results still due",
                 IDLE_LIMIT, awaited_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    tmr_current = '0;
    tmr_reload = '0;
    tmr_ctl = '0;
    tmr_flag = 1'b0;
    tmr_pending = 1'b0;
    tmr_wraps = '0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Drain: all items accepted, all results seen, then a few quiet cycles
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("ran %0d items: %0d ticks, %0d register reads, %0d register writes, %0d no-ops",
             tick_count + read_count + write_count + other_count, tick_count, read_count,
             write_count, other_count);
    $display("counter reloaded %0d times, %0d long receiver hold-offs, %0d mismatches",
             reload_events, holds_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
